// File: hw/rtl/asp_pkg.sv
package asp_pkg;

  // Default pool depth
  localparam int DEFAULT_MAX_SLOTS = 256;

  // Lifetime of a freshly claimed slot, 1.0 in Q1.15
  localparam logic [15:0] LIFE_ONE = 16'd32768;

  // Register reset values
  localparam logic [8:0]  SLOTS_IN_USE_RST = 9'd256;
  localparam logic [15:0] DECAY_RATE_RST   = 16'd256;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_RATE   = 2'd1;

  // Command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [15:0] delta_time;
  } asp_in_t;

  typedef struct packed {
    logic [7:0] slot_index;
    logic       overwrote;
    logic [8:0] live_count;
  } asp_out_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic clear_step;
    logic load;
    logic prep;
    logic issue;
    logic finish;
  } asp_ctl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clear_last;
    logic sweep_last;
    logic out_free;
  } asp_sts_t;

endpackage

// File: hw/rtl/asp_datapath.sv
module asp_datapath import asp_pkg::*; #(
  parameter int MAX_SLOTS = DEFAULT_MAX_SLOTS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  input  asp_in_t              in_data,
  input  asp_ctl_t             ctl,
  output asp_sts_t             sts,
  output logic                 out_valid,
  input  logic                 out_stall,
  output asp_out_t             out_data
);

  localparam int IW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);

  logic [8:0]    slots_in_use;
  logic [15:0]   decay_rate;
  logic [IW-1:0] search_start;
  logic [IW-1:0] addr;
  logic [CW-1:0] cnt;
  logic          cmd_tick;
  logic [31:0]   prod;
  logic [23:0]   dec;
  logic          s1_vld;
  logic [IW-1:0] s1_addr;
  logic [15:0]   rd_data;
  logic          found;
  logic [IW-1:0] slot;
  logic [CW-1:0] count;

  logic [15:0]   mem [MAX_SLOTS];

  logic [CW-1:0] n;
  logic [IW-1:0] start;
  logic [IW-1:0] addr_next;
  logic [15:0]   life_new;
  logic          we;
  logic [IW-1:0] wa;
  logic [15:0]   wd;
  logic [CW-1:0] live;

  // Active pool size: zero counts as one, clamp to the pool depth
  always_comb begin
    if (slots_in_use == 9'd0) begin
      n = CW'(1);
    end else if (32'(slots_in_use) > MAX_SLOTS) begin
      n = CW'(MAX_SLOTS);
    end else begin
      n = CW'(slots_in_use);
    end
  end

  // Next-fit start, drop a stale position
  assign start = (CW'(search_start) < n) ? search_start : '0;

  // Wrap the sweep address at the end of the active pool
  assign addr_next = (CW'(addr) == n - CW'(1)) ? '0 : addr + IW'(1);

  // Age one slot, flooring at zero
  always_comb begin
    if (rd_data == 16'd0 || dec >= {8'd0, rd_data}) begin
      life_new = 16'd0;
    end else begin
      life_new = rd_data - dec[15:0];
    end
  end

  // Single write port: clear, tick write-back, or allocate claim
  always_comb begin
    we = 1'b0;
    wa = addr;
    wd = 16'd0;
    if (ctl.clear_step) begin
      we = 1'b1;
    end else if (s1_vld && cmd_tick) begin
      we = 1'b1;
      wa = s1_addr;
      wd = life_new;
    end else if (ctl.finish && !cmd_tick) begin
      we = 1'b1;
      wa = found ? slot : '0;
      wd = LIFE_ONE;
    end
  end

  assign live = count + CW'(!cmd_tick && found);

  assign sts.clear_last = (addr == IW'(MAX_SLOTS - 1));
  assign sts.sweep_last = (cnt == n - CW'(1));
  assign sts.out_free   = !out_valid || !out_stall;

  // Lifetime store
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[addr];
  end

  // Configuration registers, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= SLOTS_IN_USE_RST;
      decay_rate   <= DECAY_RATE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SLOTS_IN_USE: slots_in_use <= cfg_data[8:0];
        REG_DECAY_RATE:   decay_rate   <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Sweep address and issue counter
  always_ff @(posedge clk) begin
    if (rst) begin
      addr   <= '0;
      cnt    <= '0;
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= ctl.issue;
      if (ctl.clear_step) begin
        addr <= addr + IW'(1);
      end else if (ctl.load) begin
        addr <= start;
        cnt  <= '0;
      end else if (ctl.issue) begin
        addr <= addr_next;
        cnt  <= cnt + CW'(1);
      end
    end
  end

  // Capture the request and form the decay step
  always_ff @(posedge clk) begin
    s1_addr <= addr;
    if (ctl.load) begin
      cmd_tick <= (in_data.cmd == CMD_TICK);
      prod     <= 32'(decay_rate) * 32'(in_data.delta_time);
    end
    if (ctl.prep) begin
      dec <= 24'((33'(prod) + 33'd256) >> 9);
    end
  end

  // Search and count over the read stage
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      found <= 1'b0;
      slot  <= '0;
      count <= '0;
    end else if (s1_vld) begin
      if (cmd_tick) begin
        if (life_new != 16'd0) begin
          count <= count + CW'(1);
        end
      end else begin
        if (rd_data != 16'd0) begin
          count <= count + CW'(1);
        end else if (!found) begin
          found <= 1'b1;
          slot  <= s1_addr;
        end
      end
    end
  end

  // Remember the claimed slot
  always_ff @(posedge clk) begin
    if (rst) begin
      search_start <= '0;
    end else if (ctl.finish && !cmd_tick && found) begin
      search_start <= slot;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_data.slot_index <= cmd_tick ? 8'd0 : 8'(slot);
      out_data.overwrote  <= !cmd_tick && !found;
      out_data.live_count <= 9'(live);
    end
  end

endmodule

// File: hw/rtl/asp_controller.sv
module asp_controller import asp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  asp_sts_t sts,
  output asp_ctl_t ctl
);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_PREP   = 6'b000100,
    S_SWEEP  = 6'b001000,
    S_DRAIN  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  // Clear the store after reset, then sequence each request: prepare, sweep the pool, drain the read stage, finish
  always_comb begin
    state_next     = state;
    ctl            = '0;
    case (state)
      S_CLEAR: begin
        ctl.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        ctl.prep   = 1'b1;
        state_next = S_SWEEP;
      end
      S_SWEEP: begin
        ctl.issue = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hw/rtl/aging_slot_pool_next_fit_core.sv
// Channel  Handshake            Payload
// in       in_valid / in_stall   in_data   (asp_in_t: cmd, delta_time)
// out      out_valid / out_stall out_data  (asp_out_t: slot_index, overwrote, live_count)
// cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each request sweeps the active pool of n slots, with one read of the
// lifetime store per slot, through a single read port and a single write port.
// After reset the store is cleared one slot per cycle, all MAX_SLOTS of them, before
// the first request is taken; configuration writes are taken at any time.
// A result waits in the output register; a stalled output holds only the finish
// of the following request.
module aging_slot_pool_next_fit_core import asp_pkg::*; #(
  parameter int MAX_SLOTS = DEFAULT_MAX_SLOTS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  asp_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output asp_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  asp_ctl_t ctl;
  asp_sts_t sts;

  // Registers accept a write in any cycle
  assign cfg_ready = 1'b1;

  asp_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  asp_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import asp_pkg::*;

  // Register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned BIG_PHASE_ITEMS = 300;
  localparam int unsigned MIXED_ITEMS = 425;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  asp_in_t              in_data;
  logic                 out_valid;
  logic                 out_stall;
  asp_out_t             out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  // Random idling on/off switches, one pair per phase
  bit calm_tx;
  bit calm_rx;
  int unsigned n_settings;

  // Pool model: lifetimes, next-fit position and registers, plus the results it predicts
  class slot_pool_scoreboard;
    bit [15:0]   life_q15 [DEFAULT_MAX_SLOTS];
    int unsigned search_pos;
    bit [8:0]    size_reg;
    bit [15:0]   rate_reg;
    asp_out_t    pending_results [$];
    int unsigned errors;
    int unsigned n_alloc;
    int unsigned n_tick;
    int unsigned n_full;
    int unsigned peak_live;

    function new();
      foreach (life_q15[i]) life_q15[i] = '0;
      search_pos = 0;
      size_reg = SLOTS_IN_USE_RST;
      rate_reg = DECAY_RATE_RST;
      errors = 0;
      n_alloc = 0;
      n_tick = 0;
      n_full = 0;
      peak_live = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
      case (idx)
        REG_SLOTS_IN_USE: size_reg = data[8:0];
        REG_DECAY_RATE:   rate_reg = data;
        default: ;
      endcase
    endfunction

    // Apply one request to the pool and queue the result it must produce
    function void note_request(asp_in_t req);
      int unsigned n;
      int unsigned start;
      int unsigned slot;
      int unsigned live;
      int unsigned i;
      bit          found;
      bit          over;
      bit [32:0]   prod;
      bit [23:0]   dec;
      asp_out_t    res;
      n = 32'(size_reg);
      if (n == 0) n = 1;
      if (n > DEFAULT_MAX_SLOTS) n = DEFAULT_MAX_SLOTS;
      slot = 0;
      over = 1'b0;
      found = 1'b0;
      if (req.cmd == CMD_ALLOC) begin
        // Next-fit: remembered position to the end, then wrap from zero
        start = (search_pos < n) ? search_pos : 0;
        for (i = start; i < n && !found; i++)
          if (life_q15[i] == 0) begin
            slot = i;
            found = 1'b1;
          end
        for (i = 0; i < start && !found; i++)
          if (life_q15[i] == 0) begin
            slot = i;
            found = 1'b1;
          end
        if (found) begin
          search_pos = slot;
        end else begin
          over = 1'b1;
          n_full++;
        end
        life_q15[slot] = LIFE_ONE;
        n_alloc++;
      end else begin
        // Q8.8 rate times Q0.16 time, rounded to Q1.15
        prod = 33'(rate_reg) * 33'(req.delta_time);
        dec = 24'((prod + 33'd256) >> 9);
        for (i = 0; i < n; i++)
          if (life_q15[i] != 0)
            life_q15[i] = (dec >= 24'(life_q15[i])) ? 16'd0 : life_q15[i] - dec[15:0];
        n_tick++;
      end
      live = 0;
      for (i = 0; i < n; i++)
        if (life_q15[i] != 0) live++;
      if (live > peak_live) peak_live = live;
      res.slot_index = slot[7:0];
      res.overwrote = over;
      res.live_count = live[8:0];
      pending_results.push_back(res);
    endfunction

    function void check_result(asp_out_t got);
      asp_out_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: slot_index %0d overwrote %0d live_count %0d",
               got.slot_index, got.overwrote, got.live_count);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.slot_index !== want.slot_index) begin
          $error("slot_index: expected %0d, got %0d", want.slot_index, got.slot_index);
          errors++;
        end
        if (got.overwrote !== want.overwrote) begin
          $error("overwrote: expected %0d, got %0d", want.overwrote, got.overwrote);
          errors++;
        end
        if (got.live_count !== want.live_count) begin
          $error("live_count: expected %0d, got %0d", want.live_count, got.live_count);
          errors++;
        end
      end
    endfunction
  endclass

  slot_pool_scoreboard sb = new();

  aging_slot_pool_next_fit_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Tick duration: edge values, short steps and the full range
  function automatic logic [15:0] pick_dt();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      case ($urandom_range(0, 4))
        0: return 16'd0;
        1: return 16'd1;
        2: return 16'd255;
        3: return 16'd256;
        default: return 16'hFFFF;
      endcase
    end
    if (r < 55) return 16'($urandom_range(0, 4095));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_rate();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd256;
      3: return 16'($urandom_range(1, 64));
      default: return 16'($urandom);
    endcase
  endfunction

  // Send one request and drop valid once it has been taken
  task automatic send_request(input logic cmd, input logic [15:0] dt);
    asp_in_t     req;
    int unsigned gap;
    req.cmd = cmd;
    req.delta_time = dt;
    gap = calm_tx ? 0 : idle_len();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = req;
    do @(posedge clk); while (in_stall);
    sb.note_request(req);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Hold off the sender until every predicted result has been taken
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Result side: check every accepted result
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Result side: random stall bursts unless this phase runs calm
  initial begin
    int unsigned len;
    out_stall = 1'b0;
    forever begin
      out_stall = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      len = calm_rx ? 0 : idle_len();
      if (len > 0) begin
        out_stall = 1'b1;
        repeat (len) @(negedge clk);
      end
    end
  end

  // Give up when nothing moves on any channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int unsigned remaining;
    int unsigned count;
    int unsigned alloc_pct;
    int unsigned size;
    logic [15:0] data;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_SLOTS_IN_USE;
    cfg_data = '0;
    calm_tx = 1'b0;
    calm_rx = 1'b0;
    n_settings = 1;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // Reset settings: fill two slots, then tick by zero, by one lsb and to death
    send_request(CMD_ALLOC, 16'd0);
    send_request(CMD_ALLOC, 16'hFFFF);
    send_request(CMD_TICK, 16'd0);
    send_request(CMD_TICK, 16'd1);
    send_request(CMD_TICK, 16'hFFFF);
    send_request(CMD_ALLOC, 16'd0);

    // Two-slot pool at the top rate: wrap, then overwrite when full
    drain();
    write_reg(REG_SLOTS_IN_USE, 16'd2);
    write_reg(REG_DECAY_RATE, 16'hFFFF);
    n_settings++;
    send_request(CMD_ALLOC, 16'd0);
    send_request(CMD_ALLOC, 16'd0);
    send_request(CMD_TICK, 16'hFFFF);

    // Undecoded indexes, zero pool size, rounding tie at the minimum rate
    drain();
    write_reg(REG_SPARE_A, 16'hFFFF);
    write_reg(REG_SPARE_B, 16'hFFFF);
    write_reg(REG_SLOTS_IN_USE, 16'd0);
    write_reg(REG_DECAY_RATE, 16'd1);
    n_settings++;
    send_request(CMD_ALLOC, 16'd0);
    send_request(CMD_ALLOC, 16'd0);
    send_request(CMD_TICK, 16'd256);
    send_request(CMD_TICK, 16'd255);

    // Advance the search position well past a pool we then shrink
    drain();
    write_reg(REG_SLOTS_IN_USE, 16'd16);
    write_reg(REG_DECAY_RATE, 16'h8000);
    n_settings++;
    repeat (6) send_request(CMD_ALLOC, 16'd0);
    drain();
    write_reg(REG_SLOTS_IN_USE, 16'd4);
    n_settings++;
    send_request(CMD_ALLOC, 16'd0);
    send_request(CMD_TICK, 16'hFFFF);

    // Full pool again: slots left outside the small pool come back live
    drain();
    write_reg(REG_SLOTS_IN_USE, 16'd256);
    write_reg(REG_DECAY_RATE, 16'd256);
    n_settings++;
    send_request(CMD_ALLOC, 16'd0);
    send_request(CMD_TICK, 16'd30000);

    // Oversized pool with no decay: fill all slots and overwrite past the end
    drain();
    write_reg(REG_SLOTS_IN_USE, 16'h01FF);
    write_reg(REG_DECAY_RATE, 16'd0);
    n_settings++;
    repeat (BIG_PHASE_ITEMS) begin
      if ($urandom_range(0, 99) < 93) send_request(CMD_ALLOC, 16'($urandom));
      else send_request(CMD_TICK, pick_dt());
    end

    // Random phases, mostly small pools, each with its own mix and idling
    remaining = MIXED_ITEMS;
    while (remaining > 0) begin
      drain();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: size = $urandom_range(1, 16);
        7, 8:                size = $urandom_range(17, 64);
        default:             size = $urandom_range(0, 511);
      endcase
      data = 16'($urandom);
      data[8:0] = 9'(size);
      write_reg(REG_SLOTS_IN_USE, data);
      write_reg(REG_DECAY_RATE, pick_rate());
      if ($urandom_range(0, 9) == 0) write_reg(REG_SPARE_B, 16'($urandom));
      n_settings++;
      calm_tx = ($urandom_range(0, 3) == 0);
      calm_rx = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0: alloc_pct = 50;
        1: alloc_pct = 75;
        default: alloc_pct = 90;
      endcase
      count = $urandom_range(20, 50);
      if (count > remaining) count = remaining;
      repeat (count) begin
        if ($urandom_range(0, 39) == 0) drain();
        if ($urandom_range(0, 99) < alloc_pct) send_request(CMD_ALLOC, 16'($urandom));
        else send_request(CMD_TICK, pick_dt());
      end
      remaining -= count;
    end

    // Wait out the last results and a full sweep beyond them
    drain();
    repeat (300) @(negedge clk);
    $display("Ran %0d allocations (%0d on a full pool) and %0d ticks over %0d settings,",
             sb.n_alloc, sb.n_full, sb.n_tick, n_settings);
    $display("with up to %0d slots live at once; %0d mismatches.", sb.peak_live, sb.errors);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      if (sb.pending_results.size() != 0)
        $error("%0d results never arrived", sb.pending_results.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
